>>> rtl/aacrtp_pkg.sv
// Package for the AAC RTP AU header section parser.
// Request structs, status and kind codes, and sizing constants. No dependencies.
`timescale 1ns / 1ps

package aacrtp_pkg;

  // Payload length counter width; the count saturates at all ones
  localparam int PAYLOAD_LEN_BITS = 16;
  localparam logic [PAYLOAD_LEN_BITS-1:0] CNT_MAX = '1;

  // Width used for offset and remainder arithmetic against the byte count
  localparam int CMP_W = ((PAYLOAD_LEN_BITS > 16) ? PAYLOAD_LEN_BITS : 16) + 1;

  // Result queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  // Results in flight (two accepted bytes of two results each) that must always fit
  localparam int FIFO_HEADROOM = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_ZERO_SIZE = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_e;

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [12:0] au_size;
    logic [14:0] au_index;
    logic [13:0] payload_offset;
    logic [15:0] payload_bytes;
    logic [24:0] total_au_bytes;
    logic [2:0]  status;
    logic        last_result;
  } out_req_t;

endpackage

>>> rtl/aac_rtp_au_header_parser.sv
// Top level of the AAC RTP AU header section parser (16-bit AU headers).
// Depends on aacrtp_pkg.
`timescale 1ns / 1ps
// A byte is registered on accept and its results then enter the result queue, from whose
// head they can be taken. Throughput: one byte per cycle unless stalled. Output drains
// one result per cycle when out_stall_i is low; a final byte that completes a header
// yields two results, so the input stalls while the 8-entry result queue holds more
// than 4 results. Reset clears all packet state and empties the queue.

module aac_rtp_au_header_parser import aacrtp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  // Input register
  logic    in_valid_q;
  in_req_t in_q;

  // Packet state
  logic [PAYLOAD_LEN_BITS-1:0] cnt_q, cnt_d;
  logic [15:0] sect_q, sect_d;
  logic [7:0]  pend_q, pend_d;
  logic [14:0] prev_q, prev_d;
  logic        have_q, have_d;
  logic [24:0] sum_q, sum_d;
  logic        zero_q, zero_d;
  logic        long_q, long_d;

  // Result queue
  out_req_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;
  logic [1:0]              n_push;
  out_req_t                r0, r1;
  logic                    pop;

  // Per-byte decode
  logic [15:0]      hdr_word;
  logic [12:0]      hdr_size;
  logic [14:0]      idx_exp;
  logic             sect_ok;
  logic [CMP_W-1:0] pos_ext, hend_ext, cnt_ext, offs_ext, remain_ext;
  logic [13:0]      hend_d;
  logic             have_entry;
  out_req_t         entry, summary;
  status_e          status;

  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = count_q > FIFO_CNT_W'(FIFO_DEPTH - FIFO_HEADROOM);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_i && !in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
  end

  // Header decode for the current byte
  assign hdr_word = {pend_q, in_q.data_byte};
  assign hdr_size = hdr_word[15:3];
  assign idx_exp  = have_q ? prev_q + 15'(hdr_word[2:0]) + 15'd1 : 15'(hdr_word[2:0]);
  assign sect_ok  = (sect_q != 16'd0) && (sect_q[3:0] == 4'd0);
  assign pos_ext  = CMP_W'(cnt_q);
  assign hend_ext = CMP_W'(sect_q[15:3]) + CMP_W'(2);

  // State update and result build
  always_comb begin
    cnt_d      = cnt_q;
    sect_d     = sect_q;
    pend_d     = pend_q;
    prev_d     = prev_q;
    have_d     = have_q;
    sum_d      = sum_q;
    zero_d     = zero_q;
    long_d     = long_q;
    have_entry = 1'b0;
    entry      = '0;
    summary    = '0;
    status     = ST_OK;
    hend_d     = '0;
    cnt_ext    = '0;
    offs_ext   = '0;
    remain_ext = '0;
    n_push     = 2'd0;
    r0         = '0;
    r1         = '0;

    if (in_valid_q) begin
      if (cnt_q == CNT_MAX) begin
        long_d = 1'b1;
      end else begin
        cnt_d = cnt_q + PAYLOAD_LEN_BITS'(1);
        if (cnt_q == '0) begin
          pend_d = in_q.data_byte;
        end else if (cnt_q == PAYLOAD_LEN_BITS'(1)) begin
          sect_d = hdr_word;
        end else if (sect_ok && (pos_ext < hend_ext)) begin
          // Even offset in the section: high byte; odd: completes a header
          if (!cnt_q[0]) begin
            pend_d = in_q.data_byte;
          end else if (!zero_q) begin
            if (hdr_size == 13'd0) begin
              zero_d = 1'b1;
            end else begin
              prev_d           = idx_exp;
              have_d           = 1'b1;
              sum_d            = sum_q + 25'(hdr_size);
              have_entry       = 1'b1;
              entry.kind       = KIND_ENTRY;
              entry.au_size    = hdr_size;
              entry.au_index   = idx_exp;
            end
          end
        end
      end

      if (in_q.last_byte) begin
        // Summary status, checked in priority order
        hend_d  = 14'(sect_d[15:3]) + 14'd2;
        cnt_ext = CMP_W'(cnt_d);
        if (long_d) begin
          status = ST_TOO_LONG;
        end else if (cnt_d < PAYLOAD_LEN_BITS'(4)) begin
          status = ST_SHORT;
        end else if ((sect_d == 16'd0) || (sect_d[3:0] != 4'd0)) begin
          status = ST_BAD_LEN;
        end else if (CMP_W'(hend_d) > cnt_ext) begin
          status = ST_TRUNC;
        end else if (zero_d) begin
          status = ST_ZERO_SIZE;
        end else begin
          status = ST_OK;
        end

        if (status == ST_OK) begin
          offs_ext   = CMP_W'(hend_d);
          remain_ext = cnt_ext - offs_ext;
        end

        summary.kind           = KIND_SUMMARY;
        summary.payload_offset = offs_ext[13:0];
        summary.payload_bytes  = remain_ext[15:0];
        summary.total_au_bytes = sum_d;
        summary.status         = status;
        summary.last_result    = 1'b1;

        // Packet done: return to reset state
        cnt_d  = '0;
        sect_d = '0;
        pend_d = '0;
        prev_d = '0;
        have_d = 1'b0;
        sum_d  = '0;
        zero_d = 1'b0;
        long_d = 1'b0;
      end

      // Entry goes ahead of the summary
      if (have_entry) begin
        r0     = entry;
        r1     = summary;
        n_push = in_q.last_byte ? 2'd2 : 2'd1;
      end else begin
        r0     = summary;
        n_push = in_q.last_byte ? 2'd1 : 2'd0;
      end
    end
  end

  // Packet state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sect_q <= '0;
      pend_q <= '0;
      prev_q <= '0;
      have_q <= 1'b0;
      sum_q  <= '0;
      zero_q <= 1'b0;
      long_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sect_q <= sect_d;
      pend_q <= pend_d;
      prev_q <= prev_d;
      have_q <= have_d;
      sum_q  <= sum_d;
      zero_q <= zero_d;
      long_q <= long_d;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + FIFO_PTR_W'(n_push);
      rptr_q  <= rptr_q + FIFO_PTR_W'(pop);
      count_q <= count_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end
  end

  // Result queue storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wptr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wptr_q + FIFO_PTR_W'(1)] <= r1;
    end
  end

  assign out_valid_o = count_q != '0;
  assign out_req_o   = mem_q[rptr_q];

  // Assertions
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_pushes_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_q.last_byte) |->
      ((n_push == 2'd1 && r0.kind == KIND_SUMMARY) ||
       (n_push == 2'd2 && r0.kind == KIND_ENTRY && r1.kind == KIND_SUMMARY)))
    else $error("final byte did not queue a summary last");

  a_bad_summary_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.kind == KIND_SUMMARY && out_req_o.status != ST_OK) |->
      (out_req_o.payload_offset == 14'd0 && out_req_o.payload_bytes == 16'd0))
    else $error("failed summary carries offset or byte count");

  a_entry_well_formed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.kind == KIND_ENTRY) |->
      (out_req_o.au_size != 13'd0 && out_req_o.status == ST_OK &&
       out_req_o.last_result == 1'b0))
    else $error("malformed AU entry");

endmodule

>>> dv/aac_rtp_au_header_parser_tb.sv
// Testbench for the AAC RTP AU header section parser: directed payload table, then
// random payloads, all checked against an in-bench parse model. Depends on aacrtp_pkg.
`timescale 1ns / 1ps

module aac_rtp_au_header_parser_tb;
  import aacrtp_pkg::*;

  localparam int NO_TYPED       = -1;   // row status left to the parse model
  localparam int NO_ZERO        = -1;   // row has no zero-size header
  localparam int MAX_LEN        = int'(CNT_MAX);
  localparam int RANDOM_BYTES   = 1450;
  localparam int WATCHDOG_LIMIT = 2000;

  // One directed payload: length field, repeated header word, data tail, optional cut
  typedef struct {
    logic [15:0] len_field;
    int          n_hdr;
    logic [15:0] hdr_word;
    int          zero_at;
    int          n_data;
    int          cut_len;
    int          exp_status;
  } pkt_row_t;

  pkt_row_t dir_rows [16] = '{
    // single max-size header completed by the last byte: entry plus summary together
    '{16'h0010, 1, 16'hFFFF, NO_ZERO, 0, 0, int'(ST_OK)},
    // smallest well-formed payload, size 1 index 0
    '{16'h0010, 1, 16'h0008, NO_ZERO, 0, 0, int'(ST_OK)},
    // zero length field, length not a multiple of 16, all-ones length
    '{16'h0000, 0, 16'h0000, NO_ZERO, 4, 0, int'(ST_BAD_LEN)},
    '{16'h0008, 0, 16'h0000, NO_ZERO, 4, 0, int'(ST_BAD_LEN)},
    '{16'hFFFF, 0, 16'h0000, NO_ZERO, 6, 0, int'(ST_BAD_LEN)},
    // under four bytes
    '{16'h0010, 1, 16'h1234, NO_ZERO, 0, 1, int'(ST_SHORT)},
    '{16'h0010, 1, 16'h1234, NO_ZERO, 0, 3, int'(ST_SHORT)},
    // early end on a header boundary and inside a header
    '{16'h0030, 3, 16'h0039, NO_ZERO, 0, 6, int'(ST_TRUNC)},
    '{16'h0030, 3, 16'h0039, NO_ZERO, 0, 5, int'(ST_TRUNC)},
    // zero size first, then zero size after one entry (later header suppressed)
    '{16'h0020, 2, 16'h0048, 0, 3, 0, int'(ST_ZERO_SIZE)},
    '{16'h0030, 3, 16'h0039, 1, 2, 0, int'(ST_ZERO_SIZE)},
    // index chain with data after the section
    '{16'h0040, 4, 16'h0A05, NO_ZERO, 10, 0, NO_TYPED},
    '{16'h0050, 5, 16'h00FF, NO_ZERO, 1, 0, NO_TYPED},
    // largest header section: max offset and max AU byte total
    '{16'hFFF0, 4095, 16'hFFFF, NO_ZERO, 0, 0, int'(ST_OK)},
    // payload of exactly the max length, then one byte more
    '{16'h0010, 1, 16'h0081, NO_ZERO, MAX_LEN - 4, 0, int'(ST_OK)},
    '{16'h0010, 1, 16'h0081, NO_ZERO, MAX_LEN - 3, 0, int'(ST_TOO_LONG)}
  };

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  // Parse model state
  logic [PAYLOAD_LEN_BITS-1:0] rx_count    = '0;
  logic [15:0]                 hdr_len_bits = '0;
  logic [7:0]                  hi_byte     = '0;
  logic [14:0]                 prev_index  = '0;
  logic                        have_prev   = 1'b0;
  logic [25:0]                 size_sum    = '0;
  logic                        zero_seen   = 1'b0;
  logic                        long_seen   = 1'b0;

  out_req_t   parsed_q [$];       // expected entries and summaries, oldest first
  int         table_status_q [$]; // typed status per directed payload
  logic [7:0] pkt_bytes [$];      // payload under construction

  out_req_t want;
  int       mismatches    = 0;
  int       results_seen  = 0;
  int       status_seen [6] = '{default: 0};
  int       bytes_sent    = 0;
  int       packets_sent  = 0;
  int       burst_left    = 0;
  int       idle_cycles   = 0;
  int       stall_run     = 0;
  logic [1:0] stall_mode  = 2'd0;

  aac_rtp_au_header_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Parse model: one accepted byte, expected results appended to parsed_q
  task automatic parse_byte(input in_req_t req);
    int         pos;
    int         hdr_bytes;
    logic [15:0] word;
    logic [14:0] idx;
    out_req_t   res;
    status_e    st;
    if (rx_count == CNT_MAX) begin
      long_seen = 1'b1;
    end else begin
      pos = int'(rx_count);
      rx_count = rx_count + PAYLOAD_LEN_BITS'(1);
      if (pos == 0) begin
        hi_byte = req.data_byte;
      end else if (pos == 1) begin
        hdr_len_bits = {hi_byte, req.data_byte};
      end else if (hdr_len_bits != 0 && hdr_len_bits[3:0] == 4'd0 &&
                   pos < 2 + int'(hdr_len_bits[15:3])) begin
        if (pos % 2 == 0) begin
          hi_byte = req.data_byte;
        end else if (!zero_seen) begin
          word = {hi_byte, req.data_byte};
          if (word[15:3] == 13'd0) begin
            zero_seen = 1'b1;
          end else begin
            idx = have_prev ? 15'(prev_index + word[2:0] + 1) : 15'(word[2:0]);
            prev_index = idx;
            have_prev  = 1'b1;
            size_sum   = size_sum + word[15:3];
            res = '0;
            res.kind     = KIND_ENTRY;
            res.au_size  = word[15:3];
            res.au_index = idx;
            parsed_q = {parsed_q, res};
          end
        end
      end
    end

    // last byte: summary after any entry, then a fresh packet
    if (req.last_byte) begin
      hdr_bytes = int'(hdr_len_bits[15:3]);
      if (long_seen) st = ST_TOO_LONG;
      else if (rx_count < 4) st = ST_SHORT;
      else if (hdr_len_bits == 0 || hdr_len_bits[3:0] != 4'd0) st = ST_BAD_LEN;
      else if (hdr_bytes > int'(rx_count) - 2) st = ST_TRUNC;
      else if (zero_seen) st = ST_ZERO_SIZE;
      else st = ST_OK;
      res = '0;
      res.kind           = KIND_SUMMARY;
      res.total_au_bytes = size_sum[24:0];
      res.status         = st;
      res.last_result    = 1'b1;
      if (st == ST_OK) begin
        res.payload_offset = 14'(2 + hdr_bytes);
        res.payload_bytes  = 16'(int'(rx_count) - 2 - hdr_bytes);
      end
      parsed_q = {parsed_q, res};
      rx_count     = '0;
      hdr_len_bits = '0;
      hi_byte      = '0;
      prev_index   = '0;
      have_prev    = 1'b0;
      size_sum     = '0;
      zero_seen    = 1'b0;
      long_seen    = 1'b0;
    end
  endtask

  // Sender: bursts of random length separated by random gaps (often none)
  task automatic send_byte(input in_req_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    bytes_sent++;
    parse_byte(req);
  endtask

  task automatic send_packet();
    in_req_t req;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      req.data_byte = pkt_bytes[i];
      req.last_byte = (i == pkt_bytes.size() - 1);
      send_byte(req);
    end
    packets_sent++;
  endtask

  task automatic push_word(input logic [15:0] w);
    pkt_bytes = {pkt_bytes, w[15:8], w[7:0]};
  endtask

  // Hold the sender until every expected result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (parsed_q.size() != 0);
    burst_left = 0;
  endtask

  // Random payload: mostly well-formed sections, some cut short, bad length or noise
  task automatic build_random_packet();
    int          sel;
    int          nh;
    int          cut;
    logic [15:0] word;
    pkt_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      nh = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      push_word(16'(nh * 16));
      repeat (nh) begin
        word = 16'($urandom);
        if ($urandom_range(0, 15) == 0) word[15:3] = '0;
        push_word(word);
      end
      repeat ($urandom_range(0, 12)) pkt_bytes = {pkt_bytes, 8'($urandom)};
      if (sel >= 68) begin
        cut = $urandom_range(1, pkt_bytes.size() - 1);
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
    end else if (sel < 88) begin
      word = 16'($urandom);
      if (sel < 82) word = '0;
      else if (word[3:0] == 4'd0) word[2] = 1'b1;
      push_word(word);
      repeat ($urandom_range(0, 10)) pkt_bytes = {pkt_bytes, 8'($urandom)};
    end else if (sel < 94) begin
      repeat ($urandom_range(1, 3)) pkt_bytes = {pkt_bytes, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 24)) pkt_bytes = {pkt_bytes, 8'($urandom)};
    end
  endtask

  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Receiver stall: random modes held for random stretches
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_run  <= $urandom_range(8, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_run[2];
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (parsed_q.size() == 0) begin
        $error("result with nothing expected: kind %0d status %0d",
               out_req_o.kind, out_req_o.status);
        mismatches++;
      end else begin
        want = parsed_q.pop_front();
        check_field("kind", want.kind, out_req_o.kind);
        check_field("au_size", want.au_size, out_req_o.au_size);
        check_field("au_index", want.au_index, out_req_o.au_index);
        check_field("payload_offset", want.payload_offset, out_req_o.payload_offset);
        check_field("payload_bytes", want.payload_bytes, out_req_o.payload_bytes);
        check_field("total_au_bytes", want.total_au_bytes, out_req_o.total_au_bytes);
        check_field("status", want.status, out_req_o.status);
        check_field("last_result", want.last_result, out_req_o.last_result);
      end
      if (out_req_o.kind == KIND_SUMMARY) begin
        if (out_req_o.status < 6) status_seen[out_req_o.status]++;
        if (table_status_q.size() != 0) begin
          if (table_status_q[0] != NO_TYPED)
            check_field("status (directed)", table_status_q[0], out_req_o.status);
          void'(table_status_q.pop_front());
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int rnd_pkts;
    int rnd_start;
    rnd_pkts = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[r]) begin
      pkt_bytes.delete();
      push_word(dir_rows[r].len_field);
      for (int h = 0; h < dir_rows[r].n_hdr; h++)
        push_word((h == dir_rows[r].zero_at) ? {13'd0, dir_rows[r].hdr_word[2:0]}
                                             : dir_rows[r].hdr_word);
      for (int k = 0; k < dir_rows[r].n_data; k++)
        pkt_bytes = {pkt_bytes, 8'(k * 37 + 5)};
      if (dir_rows[r].cut_len > 0)
        while (pkt_bytes.size() > dir_rows[r].cut_len) void'(pkt_bytes.pop_back());
      table_status_q = {table_status_q, dir_rows[r].exp_status};
      send_packet();
    end
    drain_results();

    // random payloads, with a full drain now and then
    rnd_start = bytes_sent;
    while (bytes_sent - rnd_start < RANDOM_BYTES) begin
      build_random_packet();
      send_packet();
      rnd_pkts++;
      if (rnd_pkts % 40 == 0) drain_results();
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d payloads (%0d bytes, %0d random payloads), %0d results checked",
             packets_sent, bytes_sent, rnd_pkts, results_seen);
    $display("Summaries by status: ok %0d, short %0d, bad len %0d, trunc %0d, zero %0d, long %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/aacrtp_pkg.sv
rtl/aac_rtp_au_header_parser.sv
dv/aac_rtp_au_header_parser_tb.sv
